>>> src/ccps_pkg.sv
// Shared types, codes and character tables of the password shuffler.
`default_nettype none
package ccps_pkg;

  localparam int MAX_LENGTH = 256;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int LEN_W      = 9;
  localparam int CHAR_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CNT_W      = 11;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_LEN   = 2'd1;
  localparam logic [1:0] STAT_NO_CLASS  = 2'd2;
  localparam logic [1:0] STAT_TOO_SHORT = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_FILL = 2'd1;
  localparam logic [1:0] PH_SHUF = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVOID      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SYMBOL = 3'd4;

  localparam logic [2:0] CLS_POOL = 3'd4;

  localparam logic [26*8-1:0] TXT_LOWER   = "abcdefghijklmnopqrstuvwxyz";
  localparam logic [26*8-1:0] TXT_UPPER   = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam logic [10*8-1:0] TXT_DIGIT   = "0123456789";
  localparam logic [23*8-1:0] TXT_SYMBOL  = "!@#$%^&*()-_=+[]{};:,.?";
  localparam logic [24*8-1:0] TXT_LOWER_A = "abcdefghijkmnpqrstuvwxyz";
  localparam logic [24*8-1:0] TXT_UPPER_A = "ABCDEFGHJKLMNPQRSTUVWXYZ";
  localparam logic [8*8-1:0]  TXT_DIGIT_A = "23456789";

  typedef struct packed {
    logic        kind;
    logic [31:0] random_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CHAR_W-1:0] char_code;
    logic [7:0]        position;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic word;
    logic div_step;
    logic fill_commit;
    logic rd_j;
    logic rd_b;
    logic swap;
    logic out1;
    logic out2;
  } cmd_t;

  typedef struct packed {
    logic start_err;
    logic phase_idle;
    logic phase_fill;
    logic div_last;
    logic reject;
    logic fill_single;
    logic shuf_last;
    logic out_free;
  } stat_t;

  function automatic logic [4:0] class_len(logic avoid, logic [1:0] c);
    logic [4:0] n;
    case ({avoid, c})
      3'b000:  n = 5'd26;
      3'b001:  n = 5'd26;
      3'b010:  n = 5'd10;
      3'b100:  n = 5'd24;
      3'b101:  n = 5'd24;
      3'b110:  n = 5'd8;
      default: n = 5'd23;
    endcase
    return n;
  endfunction

  function automatic logic [CHAR_W-1:0] class_char(logic avoid, logic [1:0] c,
                                                   logic [4:0] k);
    logic [7:0] ch;
    ch = 8'd0;
    case ({avoid, c})
      3'b000: if (k < 5'd26) ch = TXT_LOWER[8*(25-k) +: 8];
      3'b001: if (k < 5'd26) ch = TXT_UPPER[8*(25-k) +: 8];
      3'b010: if (k < 5'd10) ch = TXT_DIGIT[8*(9-k) +: 8];
      3'b100: if (k < 5'd24) ch = TXT_LOWER_A[8*(23-k) +: 8];
      3'b101: if (k < 5'd24) ch = TXT_UPPER_A[8*(23-k) +: 8];
      3'b110: if (k < 5'd8)  ch = TXT_DIGIT_A[8*(7-k) +: 8];
      default: if (k < 5'd23) ch = TXT_SYMBOL[8*(22-k) +: 8];
    endcase
    return ch[CHAR_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> src/ccps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ccps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/ccps_datapath.sv
// Datapath: settings, serial remainder unit, class lookup, store and result registers.
`default_nettype none
module ccps_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire logic [ccps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ccps_pkg::LEN_W-1:0]        cfg_wdata,
  input  wire ccps_pkg::in_item_t                in_data,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output ccps_pkg::out_item_t                    out_data,
  input  wire ccps_pkg::cmd_t                    cmd,
  output ccps_pkg::stat_t                        stat
);

  localparam int AW = ccps_pkg::ADDR_W;
  localparam int LW = ccps_pkg::LEN_W;
  localparam int CW = ccps_pkg::CHAR_W;
  localparam int SW = ccps_pkg::CNT_W;

  logic [LW-1:0] len_cfg_r, mind_cfg_r, mins_cfg_r;
  logic [3:0]    en_cfg_r;
  logic          avoid_cfg_r;

  logic [LW-1:0] lat_len_r;
  logic [3:0]    lat_en_r;
  logic          lat_avoid_r;
  logic [LW-1:0] lat_req_r [4];

  logic [1:0]    phase_r;
  logic [LW-1:0] fill_r;
  logic [AW-1:0] shuf_r;

  logic [31:0]   word_r;
  logic [LW-1:0] bound_r, rem_r, mrem_r;
  logic [4:0]    cnt_r;
  logic [2:0]    cls_r;
  logic [CW-1:0] a_r;

  ccps_pkg::out_item_t res1_r, res2_r, out_r;
  logic                out_valid_r;

  logic [LW-1:0] req_d [4];
  logic [SW-1:0] total_d;
  logic [1:0]    err_d;

  logic [2:0]    cls_d;
  logic [SW-1:0] acc_d;
  logic [6:0]    pool_d;
  logic [LW-1:0] bound_d;

  logic [LW:0]   rt, mt;
  logic [LW-1:0] rem_step, mrem_step;

  logic [CW-1:0] fill_ch;
  logic [6:0]    pk;
  logic          pfound;
  logic [LW:0]   fill_inc;
  logic          fill_done;

  logic          we;
  logic [AW-1:0] waddr, raddr, baddr;
  logic [CW-1:0] wdata, rdata;

  // start check on the live settings
  always_comb begin
    req_d[0] = {{(LW-1){1'b0}}, en_cfg_r[0]};
    req_d[1] = {{(LW-1){1'b0}}, en_cfg_r[1]};
    req_d[2] = en_cfg_r[2] ? ((mind_cfg_r > LW'(1)) ? mind_cfg_r : LW'(1)) : '0;
    req_d[3] = en_cfg_r[3] ? ((mins_cfg_r > LW'(1)) ? mins_cfg_r : LW'(1)) : '0;
    total_d  = SW'(req_d[0]) + SW'(req_d[1]) + SW'(req_d[2]) + SW'(req_d[3]);
    if (len_cfg_r < LW'(1) || len_cfg_r > LW'(ccps_pkg::MAX_LENGTH)) begin
      err_d = ccps_pkg::STAT_BAD_LEN;
    end else if (en_cfg_r == 4'd0) begin
      err_d = ccps_pkg::STAT_NO_CLASS;
    end else if (SW'(len_cfg_r) < total_d) begin
      err_d = ccps_pkg::STAT_TOO_SHORT;
    end else begin
      err_d = ccps_pkg::STAT_OK;
    end
  end

  // class of the next fill entry and the bound of its draw
  always_comb begin
    cls_d  = ccps_pkg::CLS_POOL;
    acc_d  = '0;
    pool_d = '0;
    for (int c = 0; c < 4; c++) begin
      if (cls_d == ccps_pkg::CLS_POOL && SW'(fill_r) < acc_d + SW'(lat_req_r[c])) begin
        cls_d = 3'(c);
      end
      acc_d = acc_d + SW'(lat_req_r[c]);
      if (lat_en_r[c]) begin
        pool_d = pool_d + 7'(ccps_pkg::class_len(lat_avoid_r, 2'(c)));
      end
    end
    if (phase_r == ccps_pkg::PH_SHUF) begin
      bound_d = LW'(shuf_r) + LW'(1);
    end else if (cls_d == ccps_pkg::CLS_POOL) begin
      bound_d = LW'(pool_d);
    end else begin
      bound_d = LW'(ccps_pkg::class_len(lat_avoid_r, cls_d[1:0]));
    end
  end

  // one restoring remainder step for the word and for 2^32
  always_comb begin
    rt = {rem_r, word_r[~cnt_r]};
    mt = {mrem_r, 1'b0};
    rem_step  = (rt >= {1'b0, bound_r}) ? LW'(rt - {1'b0, bound_r}) : LW'(rt);
    mrem_step = (mt >= {1'b0, bound_r}) ? LW'(mt - {1'b0, bound_r}) : LW'(mt);
  end

  // character for the drawn index
  always_comb begin
    pk      = rem_r[6:0];
    pfound  = 1'b0;
    fill_ch = '0;
    if (cls_r == ccps_pkg::CLS_POOL) begin
      for (int c = 0; c < 4; c++) begin
        if (lat_en_r[c] && !pfound) begin
          if (pk < 7'(ccps_pkg::class_len(lat_avoid_r, 2'(c)))) begin
            fill_ch = ccps_pkg::class_char(lat_avoid_r, 2'(c), pk[4:0]);
            pfound  = 1'b1;
          end else begin
            pk = pk - 7'(ccps_pkg::class_len(lat_avoid_r, 2'(c)));
          end
        end
      end
    end else begin
      fill_ch = ccps_pkg::class_char(lat_avoid_r, cls_r[1:0], rem_r[4:0]);
    end
  end

  assign fill_inc  = {1'b0, fill_r} + (LW+1)'(1);
  assign fill_done = fill_inc >= {1'b0, lat_len_r};

  assign baddr = (shuf_r == AW'(1)) ? {{(AW-1){1'b0}}, ~rem_r[0]} : shuf_r;
  assign raddr = cmd.rd_j ? rem_r[AW-1:0] : baddr;
  assign we    = cmd.fill_commit || (cmd.swap && shuf_r != AW'(1));
  assign waddr = cmd.fill_commit ? fill_r[AW-1:0] : rem_r[AW-1:0];
  assign wdata = cmd.fill_commit ? fill_ch : rdata;

  ccps_ram #(
    .WIDTH (CW),
    .DEPTH (ccps_pkg::MAX_LENGTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r   <= LW'(16);
      en_cfg_r    <= 4'hF;
      avoid_cfg_r <= 1'b0;
      mind_cfg_r  <= LW'(1);
      mins_cfg_r  <= LW'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ccps_pkg::REG_LENGTH:     len_cfg_r   <= cfg_wdata;
        ccps_pkg::REG_ENABLES:    en_cfg_r    <= cfg_wdata[3:0];
        ccps_pkg::REG_AVOID:      avoid_cfg_r <= cfg_wdata[0];
        ccps_pkg::REG_MIN_DIGIT:  mind_cfg_r  <= cfg_wdata;
        ccps_pkg::REG_MIN_SYMBOL: mins_cfg_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_len_r   <= LW'(16);
      lat_en_r    <= 4'hF;
      lat_avoid_r <= 1'b0;
      for (int c = 0; c < 4; c++) lat_req_r[c] <= LW'(1);
      phase_r     <= ccps_pkg::PH_IDLE;
      fill_r      <= '0;
      shuf_r      <= '0;
      bound_r     <= LW'(2);
      rem_r       <= '0;
      mrem_r      <= '0;
      cnt_r       <= '0;
      cls_r       <= ccps_pkg::CLS_POOL;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        if (err_d == ccps_pkg::STAT_OK) begin
          lat_len_r   <= len_cfg_r;
          lat_en_r    <= en_cfg_r;
          lat_avoid_r <= avoid_cfg_r;
          for (int c = 0; c < 4; c++) lat_req_r[c] <= req_d[c];
          fill_r      <= '0;
          shuf_r      <= '0;
          phase_r     <= ccps_pkg::PH_FILL;
        end else begin
          phase_r     <= ccps_pkg::PH_IDLE;
        end
      end
      if (cmd.word) begin
        bound_r <= bound_d;
        cls_r   <= cls_d;
        rem_r   <= '0;
        mrem_r  <= LW'(1);
        cnt_r   <= '0;
      end
      if (cmd.div_step) begin
        rem_r  <= rem_step;
        mrem_r <= mrem_step;
        cnt_r  <= cnt_r + 5'd1;
      end
      if (cmd.fill_commit) begin
        fill_r <= fill_inc[LW-1:0];
        if (fill_done) begin
          if (lat_len_r <= LW'(1)) begin
            phase_r <= ccps_pkg::PH_IDLE;
          end else begin
            shuf_r  <= AW'(lat_len_r - LW'(1));
            phase_r <= ccps_pkg::PH_SHUF;
          end
        end
      end
      if (cmd.swap) begin
        if (shuf_r == AW'(1)) begin
          phase_r <= ccps_pkg::PH_IDLE;
          shuf_r  <= '0;
        end else begin
          shuf_r <= shuf_r - AW'(1);
        end
      end
      if (cmd.out1 || cmd.out2) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.word) word_r <= in_data.random_word;
    if (cmd.rd_b) a_r <= rdata;
    if (cmd.start) begin
      res1_r <= '{status: err_d, char_code: '0, position: '0, last: 1'b1};
    end
    if (cmd.fill_commit) begin
      res1_r <= '{status: ccps_pkg::STAT_OK, char_code: fill_ch, position: '0, last: 1'b1};
    end
    if (cmd.swap) begin
      res1_r <= '{status: ccps_pkg::STAT_OK, char_code: a_r, position: 8'(shuf_r),
                  last: 1'b0};
      res2_r <= '{status: ccps_pkg::STAT_OK, char_code: rdata, position: '0, last: 1'b1};
    end
    if (cmd.out1) out_r <= res1_r;
    if (cmd.out2) out_r <= res2_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat.start_err   = err_d != ccps_pkg::STAT_OK;
  assign stat.phase_idle  = phase_r == ccps_pkg::PH_IDLE;
  assign stat.phase_fill  = phase_r == ccps_pkg::PH_FILL;
  assign stat.div_last    = cnt_r == 5'd31;
  assign stat.reject      = (~word_r[31:LW] == '0) && (~word_r[LW-1:0] < mrem_r);
  assign stat.fill_single = fill_done && lat_len_r <= LW'(1);
  assign stat.shuf_last   = shuf_r == AW'(1);
  assign stat.out_free    = !out_valid_r || out_ready;

  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ccps_pkg::PH_SHUF |-> shuf_r != '0 && LW'(shuf_r) < lat_len_r)
    else $error("shuffle index outside password");
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ccps_pkg::PH_FILL |-> fill_r < lat_len_r)
    else $error("fill count past password length");
  assert property (@(posedge clk) disable iff (!rst_n)
    rem_r < bound_r && mrem_r < bound_r)
    else $error("remainder not below bound");

endmodule
`default_nettype wire

>>> src/ccps_ctrl.sv
// Controller: sequences start checks, draws, fill, shuffle reads and result transfers.
`default_nettype none
module ccps_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_kind,
  output logic                 in_ready,
  input  wire ccps_pkg::stat_t stat,
  output ccps_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_WAIT  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_RDA   = 3'd3;
  localparam logic [2:0] S_RDB   = 3'd4;
  localparam logic [2:0] S_EMIT1 = 3'd5;
  localparam logic [2:0] S_EMIT2 = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       two_r, two_nxt;

  assign in_ready = state_r == S_WAIT;

  always_comb begin
    state_nxt = state_r;
    two_nxt   = two_r;
    cmd       = '0;
    unique case (state_r)
      S_WAIT: begin
        if (in_valid) begin
          if (!in_kind) begin
            cmd.start = 1'b1;
            if (stat.start_err) begin
              two_nxt   = 1'b0;
              state_nxt = S_EMIT1;
            end
          end else if (!stat.phase_idle) begin
            cmd.word  = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.reject) begin
          state_nxt = S_WAIT;
        end else if (stat.phase_fill) begin
          cmd.fill_commit = 1'b1;
          two_nxt         = 1'b0;
          state_nxt       = stat.fill_single ? S_EMIT1 : S_WAIT;
        end else begin
          cmd.rd_j  = 1'b1;
          state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        cmd.rd_b  = 1'b1;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.swap  = 1'b1;
        two_nxt   = stat.shuf_last;
        state_nxt = S_EMIT1;
      end
      S_EMIT1: begin
        if (stat.out_free) begin
          cmd.out1  = 1'b1;
          state_nxt = two_r ? S_EMIT2 : S_WAIT;
        end
      end
      S_EMIT2: begin
        if (stat.out_free) begin
          cmd.out2  = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      default: state_nxt = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WAIT;
      two_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      two_r   <= two_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/class_constrained_password_shuffler.sv
// Top level of the class-constrained password shuffler.
// Start item: an error result goes to the output register once that register is free.
// Random word: accept, shared bit-serial remainder unit (S_DIV), check; length one adds an
// output, a shuffle step two reads, a swap and an output, the last step a second output.
// One item is in work at a time; the output register takes one result, a second waits inside.
// Synchronous reset loads the default settings, idles the phase; the store is not cleared.
`default_nettype none
module class_constrained_password_shuffler (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire ccps_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output ccps_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ccps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ccps_pkg::LEN_W-1:0]     cfg_wdata
);

  ccps_pkg::cmd_t  cmd;
  ccps_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  ccps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ccps_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the class-constrained password shuffler.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import ccps_pkg::*;

  localparam int NUM_RANDOM  = 1600;
  localparam int CYCLE_LIMIT = 6000000;

  logic clk;
  logic rst_n;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0] cfg_wdata;

  class_constrained_password_shuffler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // settings as written and as latched at the last good start
  logic [8:0] set_len, set_min_dig, set_min_sym;
  logic [3:0] set_en;
  logic set_avoid;
  int unsigned act_len, act_req[4];
  logic [3:0] act_en;
  logic act_avoid;
  logic [1:0] gen_phase;
  int unsigned gen_fill, gen_shuf;
  logic [CHAR_W-1:0] pw_chars[MAX_LENGTH];

  in_item_t pending_items[$];
  out_item_t expected_chars[$];
  int errors = 0;
  int mismatches = 0;
  int unsigned cycles = 0;
  int in_wait, out_wait;

  function automatic int unsigned class_size(logic avoid, int c);
    int unsigned n[2][4] = '{'{26, 26, 10, 23}, '{24, 24, 8, 23}};
    return n[avoid][c];
  endfunction

  function automatic logic [CHAR_W-1:0] class_letter(logic avoid, int c, int unsigned k);
    string s;
    byte b;
    case (c)
      0: s = avoid ? "abcdefghijkmnpqrstuvwxyz" : "abcdefghijklmnopqrstuvwxyz";
      1: s = avoid ? "ABCDEFGHJKLMNPQRSTUVWXYZ" : "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
      2: s = avoid ? "23456789" : "0123456789";
      default: s = "!@#$%^&*()-_=+[]{};:,.?";
    endcase
    b = s[k];
    return b[CHAR_W-1:0];
  endfunction

  function automatic logic draw_index(logic [31:0] r, int unsigned bound,
                                      output int unsigned idx);
    longint unsigned lim;
    lim = 64'h1_0000_0000 - (64'h1_0000_0000 % bound);
    idx = r % bound;
    return {32'd0, r} < lim;
  endfunction

  function automatic out_item_t make_out(logic [1:0] st, logic [6:0] ch, logic [7:0] pos,
                                         logic lst);
    out_item_t o;
    o.status = st; o.char_code = ch; o.position = pos; o.last = lst;
    return o;
  endfunction

  function automatic void add_expected(out_item_t o);
    expected_chars.insert(expected_chars.size(), o);
  endfunction

  task automatic predict_password(in_item_t it);
    int unsigned req[4], total, k, acc, bound, idx, pool, i;
    int cls;
    logic [CHAR_W-1:0] ch, t;
    if (it.kind == 1'b0) begin
      gen_phase = PH_IDLE;
      if (set_len < 1 || set_len > MAX_LENGTH) begin
        add_expected(make_out(STAT_BAD_LEN, 7'd0, 8'd0, 1'b1)); return;
      end
      if (set_en == 4'd0) begin
        add_expected(make_out(STAT_NO_CLASS, 7'd0, 8'd0, 1'b1)); return;
      end
      req[0] = set_en[0];
      req[1] = set_en[1];
      req[2] = set_en[2] ? (set_min_dig > 1 ? set_min_dig : 1) : 0;
      req[3] = set_en[3] ? (set_min_sym > 1 ? set_min_sym : 1) : 0;
      total = req[0] + req[1] + req[2] + req[3];
      if (set_len < total) begin
        add_expected(make_out(STAT_TOO_SHORT, 7'd0, 8'd0, 1'b1)); return;
      end
      act_len = set_len; act_en = set_en; act_avoid = set_avoid;
      act_req = req;
      gen_fill = 0; gen_shuf = 0; gen_phase = PH_FILL;
    end else if (gen_phase == PH_FILL) begin
      k = gen_fill; cls = -1; acc = 0;
      for (int c = 0; c < 4; c++) begin
        if (cls < 0 && k < acc + act_req[c]) cls = c;
        acc += act_req[c];
      end
      pool = 0;
      for (int c = 0; c < 4; c++) if (act_en[c]) pool += class_size(act_avoid, c);
      bound = (cls >= 0) ? class_size(act_avoid, cls) : pool;
      if (!draw_index(it.random_word, bound, idx)) return;
      if (cls >= 0) ch = class_letter(act_avoid, cls, idx);
      else begin
        ch = 0;
        for (int c = 0; c < 4; c++) begin
          if (act_en[c]) begin
            if (idx < class_size(act_avoid, c)) begin
              ch = class_letter(act_avoid, c, idx); break;
            end
            idx -= class_size(act_avoid, c);
          end
        end
      end
      pw_chars[k] = ch;
      gen_fill = k + 1;
      if (gen_fill >= act_len) begin
        if (act_len <= 1) begin
          gen_phase = PH_IDLE;
          add_expected(make_out(STAT_OK, pw_chars[0], 8'd0, 1'b1));
        end else begin
          gen_shuf = act_len - 1; gen_phase = PH_SHUF;
        end
      end
    end else if (gen_phase == PH_SHUF) begin
      i = gen_shuf;
      if (!draw_index(it.random_word, i + 1, idx)) return;
      t = pw_chars[i]; pw_chars[i] = pw_chars[idx]; pw_chars[idx] = t;
      if (i == 1) begin
        add_expected(make_out(STAT_OK, pw_chars[1], 8'd1, 1'b0));
        add_expected(make_out(STAT_OK, pw_chars[0], 8'd0, 1'b1));
        gen_phase = PH_IDLE; gen_shuf = 0;
      end else begin
        add_expected(make_out(STAT_OK, pw_chars[i], i[7:0], 1'b0));
        gen_shuf = i - 1;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_password(in_data);
      if (in_wait > 0 || pending_items.size() == 0) begin
        in_valid <= 1'b0;
        if (in_wait > 0) in_wait <= in_wait - 1;
      end else begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
        in_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected transfer %p", out_data);
        end else begin
          exp_item = expected_chars.pop_front();
          if (out_data.status !== exp_item.status || out_data.char_code !== exp_item.char_code
              || out_data.position !== exp_item.position || out_data.last !== exp_item.last)
          begin
            errors++;
            if (mismatches++ < 10) $display("mismatch: expected %p got %p", exp_item, out_data);
          end
        end
      end
      if (out_wait > 0) begin
        out_ready <= 1'b0;
        out_wait <= out_wait - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready)
          out_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LENGTH:     set_len = val;
      REG_ENABLES:    set_en = val[3:0];
      REG_AVOID:      set_avoid = val[0];
      REG_MIN_DIGIT:  set_min_dig = val;
      default:        set_min_sym = val;
    endcase
  endtask

  task automatic setup(int unsigned len, int unsigned en, int unsigned av, int unsigned md,
                       int unsigned ms);
    write_reg(REG_LENGTH, len); write_reg(REG_ENABLES, en); write_reg(REG_AVOID, av);
    write_reg(REG_MIN_DIGIT, md); write_reg(REG_MIN_SYMBOL, ms);
  endtask

  task automatic queue_item(logic kind, logic [31:0] w);
    in_item_t it;
    it.kind = kind; it.random_word = w;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic drain;
    while (pending_items.size() != 0 || in_valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // one password: start plus the given number of words, some near rejection limits
  task automatic queue_password(int unsigned words);
    queue_item(0, $urandom);
    for (int unsigned n = 0; n < words; n++)
      queue_item(1, ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40)
                                                 : $urandom);
  endtask

  initial begin
    int unsigned len, sent;
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_wdata = '0;
    set_len = 16; set_en = 15; set_avoid = 0; set_min_dig = 1; set_min_sym = 1;
    act_len = 16; act_en = 15; act_avoid = 0; act_req = '{1, 1, 1, 1};
    gen_phase = PH_IDLE; gen_fill = 0; gen_shuf = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored word, error cases, length one, extremes
    queue_item(1, 32'hFFFF_FFFF);
    queue_item(1, 32'h0);
    drain();
    setup(0, 15, 0, 1, 1);   queue_item(0, 0); drain();
    setup(257, 15, 0, 1, 1); queue_item(0, 0); drain();
    setup(511, 15, 0, 1, 1); queue_item(0, 0); drain();
    setup(4, 0, 0, 1, 1);    queue_item(0, 0); drain();
    setup(4, 15, 0, 511, 511); queue_item(0, 0); drain();
    setup(1, 1, 1, 0, 0);
    queue_item(0, 0); queue_item(1, 32'hFFFF_FFFF); queue_item(1, 32'd5); drain();
    setup(2, 12, 1, 0, 0);
    queue_item(0, 0); queue_item(1, 0); queue_item(1, 32'hFFFF_FFFE);
    queue_item(1, 32'h7FFF_FFFF); drain();
    setup(5, 15, 0, 2, 0);
    queue_item(0, 0); repeat (3) queue_item(1, $urandom);
    queue_password(8); drain();
    setup(256, 4, 1, 256, 0); queue_password(300); drain();

    sent = 0;
    while (sent < NUM_RANDOM) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300) : $urandom_range(1, 12);
      setup(len, $urandom_range(0, 15), $urandom_range(0, 1),
            $urandom_range(0, 7) == 0 ? $urandom_range(0, 511) : $urandom_range(0, 3),
            $urandom_range(0, 7) == 0 ? $urandom_range(0, 511) : $urandom_range(0, 3));
      for (int p = $urandom_range(1, 3); p > 0; p--) begin
        int unsigned w;
        w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len) : 2 * len + 4;
        queue_password(w);
        sent += w + 1;
      end
      drain();
    end
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
